// File: rtl/core/rdp_pkg.sv
// Shared widths, command and status codes for the positional ring deque.
package rdp_pkg;

  localparam int DEPTH_DEF = 128;

  localparam int CMD_W   = 3;
  localparam int VAL_W   = 32;
  localparam int POS_W   = 8;
  localparam int STAT_W  = 2;
  localparam int FOUND_W = 8;
  localparam int CNTO_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_INSERT_AT  = 3'd4,
    CMD_REMOVE_AT  = 3'd5,
    CMD_SEARCH     = 3'd6
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

endpackage

// File: rtl/core/ring_deque_positional_core.sv
// Top level of the positional ring deque: sequencer, ring pointers and result register.
//
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------------
//  in       | in_valid / in_stall  | in_command, in_value, in_position
//  out      | out_valid / out_stall| out_status, out_data_out, out_found_position,
//           |                      | out_count_now
//
// Push, unused and flagged commands need no RAM read; pops do one RAM read.
// Insert at moves each element from the position on one slot back (an empty deque
// takes the word directly); remove at reads the removed word and moves each later one
// forward; search compares in order. Each element goes through a registered RAM read.
// Synchronous reset empties the deque; no clearing pass runs.
// A word waiting on a stalled output does not block the next input word; the
// following result waits for the output register to free.
module ring_deque_positional_core #(
  parameter int DEPTH = rdp_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [rdp_pkg::CMD_W-1:0]           in_command,
  input  logic signed [rdp_pkg::VAL_W-1:0]    in_value,
  input  logic [rdp_pkg::POS_W-1:0]           in_position,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [rdp_pkg::STAT_W-1:0]          out_status,
  output logic signed [rdp_pkg::VAL_W-1:0]    out_data_out,
  output logic [rdp_pkg::FOUND_W-1:0]         out_found_position,
  output logic [rdp_pkg::CNTO_W-1:0]          out_count_now
);

  import rdp_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_POP_DAT,
    S_INS_RD,
    S_INS_WR,
    S_INS_FIN,
    S_REM_RD0,
    S_REM_DAT,
    S_REM_RD,
    S_REM_WR,
    S_REM_FIN,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_FIN
  } state_t;

  state_t                state_r;
  logic [AW-1:0]         head_r;
  logic [AW-1:0]         tail_r;
  logic [CW-1:0]         cnt_r;
  logic [CW-1:0]         p_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [VAL_W-1:0]      val_r;
  logic [POS_W-1:0]      pos_r;
  status_t               res_status_r;
  logic [VAL_W-1:0]      res_data_r;
  logic [FOUND_W-1:0]    res_found_r;
  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [VAL_W-1:0]      out_data_r;
  logic [FOUND_W-1:0]    out_found_r;
  logic [CNTO_W-1:0]     out_count_r;

  logic [AW-1:0]         head_inc;
  logic [AW-1:0]         head_dec;
  logic [AW-1:0]         tail_inc;
  logic [AW-1:0]         tail_dec;
  logic                  is_empty;
  logic                  is_full;
  logic [XW-1:0]         pos_x;
  logic [XW-1:0]         cnt_x;
  logic [XW-1:0]         p_x;
  logic [CW-1:0]         pos_m1;
  logic                  ins_bad;
  logic                  rem_bad;
  logic [CW:0]           p_inc_w;
  logic [CW:0]           p_inc2_w;
  logic [CW:0]           cnt_w;

  logic [CW-1:0]         slot_off;
  logic [AW-1:0]         slot_idx;

  logic                  ram_we;
  logic [AW-1:0]         ram_waddr;
  logic [VAL_W-1:0]      ram_wdata;
  logic [AW-1:0]         ram_raddr;
  logic [VAL_W-1:0]      ram_rdata;

  always_comb begin
    head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
    head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
    tail_inc = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
    tail_dec = (tail_r == '0) ? AW'(DEPTH - 1) : tail_r - AW'(1);
    is_empty = (cnt_r == '0);
    is_full  = (cnt_r >= CW'(DEPTH));
    pos_x    = XW'(pos_r);
    cnt_x    = XW'(cnt_r);
    p_x      = XW'(p_r);
    pos_m1   = CW'(pos_r - POS_W'(1));
    ins_bad  = (pos_r == '0) || (pos_x > cnt_x + XW'(1));
    rem_bad  = (pos_r == '0) || (pos_x > cnt_x);
    p_inc_w  = {1'b0, p_r} + (CW+1)'(1);
    p_inc2_w = {1'b0, p_r} + (CW+1)'(2);
    cnt_w    = {1'b0, cnt_r};
  end

  always_comb begin
    case (state_r)
      S_INS_RD:  slot_off = p_r - CW'(1);
      S_INS_WR:  slot_off = p_r;
      S_INS_FIN: slot_off = pos_m1;
      S_REM_RD0: slot_off = pos_m1;
      S_REM_RD:  slot_off = CW'(p_inc_w);
      S_REM_WR:  slot_off = p_r;
      S_SRCH_RD: slot_off = p_r;
      default:   slot_off = '0;
    endcase
  end

  rdp_slot #(
    .DEPTH (DEPTH)
  ) u_slot (
    .base   (head_r),
    .offset (slot_off),
    .slot   (slot_idx)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot_idx;
    ram_wdata = val_r;
    ram_raddr = slot_idx;
    case (state_r)
      S_EXEC: begin
        case (cmd_r)
          CMD_PUSH_BACK: begin
            ram_we    = !is_full;
            ram_waddr = is_empty ? tail_r : tail_inc;
          end
          CMD_PUSH_FRONT: begin
            ram_we    = !is_full;
            ram_waddr = is_empty ? head_r : head_dec;
          end
          CMD_POP_FRONT: ram_raddr = head_r;
          CMD_POP_BACK:  ram_raddr = tail_r;
          CMD_INSERT_AT: begin
            ram_we    = !is_full && !ins_bad && is_empty;
            ram_waddr = tail_r;
          end
          default: ram_we = 1'b0;
        endcase
      end
      S_INS_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      S_INS_FIN: ram_we = 1'b1;
      S_REM_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
      end
      default: ram_we = 1'b0;
    endcase
  end

  rdp_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r   <= in_command;
            val_r   <= in_value;
            pos_r   <= in_position;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_data_r  <= '0;
          res_found_r <= '0;
          case (cmd_r)
            CMD_PUSH_BACK: begin
              state_r <= S_FIN;
              if (is_full) begin
                res_status_r <= ST_FULL;
              end else begin
                res_status_r <= ST_OK;
                if (!is_empty) tail_r <= tail_inc;
                cnt_r <= cnt_r + CW'(1);
              end
            end
            CMD_PUSH_FRONT: begin
              state_r <= S_FIN;
              if (is_full) begin
                res_status_r <= ST_FULL;
              end else begin
                res_status_r <= ST_OK;
                if (!is_empty) head_r <= head_dec;
                cnt_r <= cnt_r + CW'(1);
              end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (is_empty) begin
                res_status_r <= ST_EMPTY;
                state_r      <= S_FIN;
              end else begin
                res_status_r <= ST_OK;
                state_r      <= S_POP_DAT;
              end
            end
            CMD_INSERT_AT: begin
              if (is_full) begin
                res_status_r <= ST_FULL;
                state_r      <= S_FIN;
              end else if (ins_bad) begin
                res_status_r <= ST_RANGE;
                state_r      <= S_FIN;
              end else if (is_empty) begin
                res_status_r <= ST_OK;
                cnt_r        <= cnt_r + CW'(1);
                state_r      <= S_FIN;
              end else begin
                res_status_r <= ST_OK;
                tail_r       <= tail_inc;
                p_r          <= cnt_r;
                state_r      <= (cnt_x >= pos_x) ? S_INS_RD : S_INS_FIN;
              end
            end
            CMD_REMOVE_AT: begin
              if (rem_bad) begin
                res_status_r <= ST_RANGE;
                state_r      <= S_FIN;
              end else begin
                res_status_r <= ST_OK;
                p_r          <= pos_m1;
                state_r      <= S_REM_RD0;
              end
            end
            CMD_SEARCH: begin
              res_status_r <= ST_OK;
              p_r          <= '0;
              state_r      <= is_empty ? S_FIN : S_SRCH_RD;
            end
            default: begin
              res_status_r <= ST_OK;
              state_r      <= S_FIN;
            end
          endcase
        end
        S_POP_DAT: begin
          res_data_r <= ram_rdata;
          cnt_r      <= cnt_r - CW'(1);
          if (cnt_r > CW'(1)) begin
            if (cmd_r == CMD_POP_FRONT) head_r <= head_inc;
            else tail_r <= tail_dec;
          end
          state_r <= S_FIN;
        end
        S_INS_RD: state_r <= S_INS_WR;
        S_INS_WR: begin
          p_r     <= p_r - CW'(1);
          state_r <= (p_x > pos_x) ? S_INS_RD : S_INS_FIN;
        end
        S_INS_FIN: begin
          cnt_r   <= cnt_r + CW'(1);
          state_r <= S_FIN;
        end
        S_REM_RD0: state_r <= S_REM_DAT;
        S_REM_DAT: begin
          res_data_r <= ram_rdata;
          state_r    <= (p_inc_w < cnt_w) ? S_REM_RD : S_REM_FIN;
        end
        S_REM_RD: state_r <= S_REM_WR;
        S_REM_WR: begin
          p_r     <= CW'(p_inc_w);
          state_r <= (p_inc2_w < cnt_w) ? S_REM_RD : S_REM_FIN;
        end
        S_REM_FIN: begin
          if (cnt_r > CW'(1)) tail_r <= tail_dec;
          cnt_r   <= cnt_r - CW'(1);
          state_r <= S_FIN;
        end
        S_SRCH_RD: state_r <= S_SRCH_CMP;
        S_SRCH_CMP: begin
          if (ram_rdata == val_r) begin
            res_found_r <= FOUND_W'(p_inc_w);
            state_r     <= S_FIN;
          end else begin
            p_r     <= CW'(p_inc_w);
            state_r <= (p_inc_w < cnt_w) ? S_SRCH_RD : S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_data_r   <= res_data_r;
            out_found_r  <= res_found_r;
            out_count_r  <= CNTO_W'(cnt_r);
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall           = (state_r != S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_data_out       = out_data_r;
  assign out_found_position = out_found_r;
  assign out_count_now      = out_count_r;

endmodule

// File: rtl/core/rdp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/rdp_slot.sv
// Shared ring slot unit: head index plus element offset, wrapped at the ring depth.
module rdp_slot #(
  parameter int DEPTH = 128
) (
  input  logic [$clog2(DEPTH)-1:0]   base,
  input  logic [$clog2(DEPTH+1)-1:0] offset,
  output logic [$clog2(DEPTH)-1:0]   slot
);

  localparam int AW = $clog2(DEPTH);
  localparam int SW = AW + 2;

  logic [SW-1:0] sum;
  logic [SW-1:0] wrapped;

  always_comb begin
    sum     = SW'(base) + SW'(offset);
    wrapped = sum - SW'(DEPTH);
    slot    = (sum >= SW'(DEPTH)) ? AW'(wrapped) : AW'(sum);
  end

endmodule
